FILE: design/fkin_pkg.sv
// ----------------------------------------------------------------------------
// fkin_pkg
// Shared types, constants and fixed-point helpers of the seven-joint
// forward kinematics core.
// ----------------------------------------------------------------------------
package fkin_pkg;

	localparam int ANGLE_W = 18;
	localparam int ROT_W   = 18;
	localparam int POS_W   = 20;
	localparam int LINK_W  = 16;
	localparam int VAL_W   = 32;
	localparam int XY_W    = 34;
	localparam int Z_W     = 32;

	localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [Z_W-1:0]  HALF_PI_Q28     = 32'sd421657428;
	localparam logic signed [Z_W-1:0]  PI_Q28          = 32'sd843314857;
	localparam logic signed [23:0]     ROT_LIMIT       = 24'sd65536;
	localparam logic signed [23:0]     POS_LIMIT       = 24'sd327680;

	localparam logic [LINK_W-1:0] LINK_A_RST = 16'd5112;
	localparam logic [LINK_W-1:0] LINK_B_RST = 16'd25559;
	localparam logic [LINK_W-1:0] LINK_C_RST = 16'd13107;
	localparam logic [LINK_W-1:0] LINK_D_RST = 16'd20349;

	typedef enum logic [1:0] {
		REG_LINK_A = 2'd0,
		REG_LINK_B = 2'd1,
		REG_LINK_C = 2'd2,
		REG_LINK_D = 2'd3
	} reg_idx_t;

	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		val_t s1, c1, s2, c2, s3, c3, s4, c4, s5, c5, s6, c6, s7, c7;
		val_t c4s6, c4c5, s4s6, s5s7, s4c6, s5c6, s5c4, s4c5, s4s5, c5s7;
		val_t s5s6, s3s5, s2c3, c5c7, c2s3, c4c6, bs4, bc4, as2, cs2, cc2;
		val_t c4c5c6, c4c5s6, s5c6s7, c4s5s7, s5c6c7, c4s5c7, s4c5c6, s4s5c7;
		val_t c3s5s6, s3s5s6, s4c5s6, as4c6, s4s5s7, ac4c6;
		val_t e1, e2, e3, e4, ac4c5s6, as4c5s6, as3s5s6, ac3s5s6;
		val_t s3s5s6c2, s2s3s5s6, as2s3s5s6, p1, q1, r0, r2;
		val_t p1c3, p1c2s3, p1s2, q1c3, q1c2s3, q1s2;
		val_t r0s3, r0c2, r2s2, r0s2c3, r2c2;
		val_t e6, e8, p0, p2, q0, q2;
		val_t p0s3, p0c2, p2s2, p0s2c3, p2c2, p1s2s3;
		val_t q0s3, q0c2, q2s2, q0s2c3, q2c2, q1s2s3;
		val_t r0c2c3, e6c2, e8s2, e6s3, e6s2c3, e8c2, as3s5s6c2;
		val_t p0c2c3, q0c2c3, e6c2c3, u0c1, u0s1, u1c1, u1s1, u2c1, u2s1;
		val_t v2c1, v2s1, wc1, ws1, m6, m7, m8, m11;
		val_t v0c1, v0s1, v1c1, v1s1, e9c1, e9s1;
	} kin_t;

	function automatic logic signed [Z_W-1:0] atan_q28(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0:  r = 32'sd210828714;
			1:  r = 32'sd124459457;
			2:  r = 32'sd65760959;
			3:  r = 32'sd33381290;
			4:  r = 32'sd16755422;
			5:  r = 32'sd8385879;
			6:  r = 32'sd4193963;
			7:  r = 32'sd2097109;
			8:  r = 32'sd1048571;
			9:  r = 32'sd524287;
			10: r = 32'sd262144;
			11: r = 32'sd131072;
			12: r = 32'sd65536;
			13: r = 32'sd32768;
			14: r = 32'sd16384;
			15: r = 32'sd8192;
			16: r = 32'sd4096;
			17: r = 32'sd2048;
			18: r = 32'sd1024;
			19: r = 32'sd512;
			20: r = 32'sd256;
			21: r = 32'sd128;
			22: r = 32'sd64;
			23: r = 32'sd32;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q24 product, rounded half up
	function automatic val_t mq(input val_t a, input val_t b);
		logic signed [63:0] p;
		p = a * b;
		p = p + 64'sd8388608;
		return p[55:24];
	endfunction

	// Q24 to Q16 with rounding and clamp
	function automatic logic signed [23:0] emit(input val_t v, input logic signed [23:0] lim);
		logic signed [VAL_W-1:0] t;
		logic signed [23:0]      r;
		t = (v + 32'sd128) >>> 8;
		r = t[23:0];
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

endpackage

FILE: design/seven_joint_arm_forward_kinematics_core.sv
// ----------------------------------------------------------------------------
// seven_joint_arm_forward_kinematics_core
// Closed-form forward kinematics of a seven-joint serial arm: seven joint
// angles in, 3x3 tool rotation and tool position out.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive angle_0..angle_6 and raise start; the beat is taken at
//   any edge with start high and busy low. busy stays low, so a new beat can
//   be taken every cycle.
//   Result beat: done is high for one cycle with rot_00..rot_22 and
//   pos_x/y/z valid in that cycle. The receiver cannot stall.
//   Path from start to done: quadrant fold, one CORDIC stage per
//   iteration, rounding, six multiply levels of the product network,
//   output rounding/clamp. Throughput: one beat per cycle, set by the fully
//   pipelined CORDIC lanes and multiplier levels.
//   Link lengths link_a..link_d sit on the APB port at 0x0, 0x4, 0x8, 0xC.
//   They must be written by the user only while no beat is in flight;
//   the block does not enforce it. Reset clears all valid bits and loads the
//   default link lengths; beats in flight at reset are dropped.
// ----------------------------------------------------------------------------
module seven_joint_arm_forward_kinematics_core #(
	parameter int CORDIC_STEPS = 18
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [fkin_pkg::ANGLE_W-1:0] angle_0,
	input  logic signed [fkin_pkg::ANGLE_W-1:0] angle_1,
	input  logic signed [fkin_pkg::ANGLE_W-1:0] angle_2,
	input  logic signed [fkin_pkg::ANGLE_W-1:0] angle_3,
	input  logic signed [fkin_pkg::ANGLE_W-1:0] angle_4,
	input  logic signed [fkin_pkg::ANGLE_W-1:0] angle_5,
	input  logic signed [fkin_pkg::ANGLE_W-1:0] angle_6,
	output logic                                done,
	output logic signed [fkin_pkg::ROT_W-1:0]   rot_00,
	output logic signed [fkin_pkg::ROT_W-1:0]   rot_01,
	output logic signed [fkin_pkg::ROT_W-1:0]   rot_02,
	output logic signed [fkin_pkg::ROT_W-1:0]   rot_10,
	output logic signed [fkin_pkg::ROT_W-1:0]   rot_11,
	output logic signed [fkin_pkg::ROT_W-1:0]   rot_12,
	output logic signed [fkin_pkg::ROT_W-1:0]   rot_20,
	output logic signed [fkin_pkg::ROT_W-1:0]   rot_21,
	output logic signed [fkin_pkg::ROT_W-1:0]   rot_22,
	output logic signed [fkin_pkg::POS_W-1:0]   pos_x,
	output logic signed [fkin_pkg::POS_W-1:0]   pos_y,
	output logic signed [fkin_pkg::POS_W-1:0]   pos_z,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [3:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	// ---------------- configuration ----------------
	logic [fkin_pkg::LINK_W-1:0] link_a_q, link_b_q, link_c_q, link_d_q;
	fkin_pkg::reg_idx_t          ridx;

	assign ridx   = fkin_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_a_q <= fkin_pkg::LINK_A_RST;
			link_b_q <= fkin_pkg::LINK_B_RST;
			link_c_q <= fkin_pkg::LINK_C_RST;
			link_d_q <= fkin_pkg::LINK_D_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (ridx)
				fkin_pkg::REG_LINK_A: link_a_q <= pwdata[fkin_pkg::LINK_W-1:0];
				fkin_pkg::REG_LINK_B: link_b_q <= pwdata[fkin_pkg::LINK_W-1:0];
				fkin_pkg::REG_LINK_C: link_c_q <= pwdata[fkin_pkg::LINK_W-1:0];
				fkin_pkg::REG_LINK_D: link_d_q <= pwdata[fkin_pkg::LINK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			fkin_pkg::REG_LINK_A: prdata = {16'd0, link_a_q};
			fkin_pkg::REG_LINK_B: prdata = {16'd0, link_b_q};
			fkin_pkg::REG_LINK_C: prdata = {16'd0, link_c_q};
			fkin_pkg::REG_LINK_D: prdata = {16'd0, link_d_q};
			default:              prdata = '0;
		endcase
	end

	fkin_pkg::val_t la, lb, lc, ld;
	assign la = {8'd0, link_a_q, 8'd0};
	assign lb = {8'd0, link_b_q, 8'd0};
	assign lc = {8'd0, link_c_q, 8'd0};
	assign ld = {8'd0, link_d_q, 8'd0};

	// ---------------- sine / cosine lanes ----------------
	logic signed [fkin_pkg::ANGLE_W-1:0] ang [0:6];
	fkin_pkg::val_t                      sn [0:6];
	fkin_pkg::val_t                      cs [0:6];
	logic [6:0]                          cvld;

	assign ang[0] = angle_0;
	assign ang[1] = angle_1;
	assign ang[2] = angle_2;
	assign ang[3] = angle_3;
	assign ang[4] = angle_4;
	assign ang[5] = angle_5;
	assign ang[6] = angle_6;

	for (genvar j = 0; j < 7; j++) begin : g_lane
		fkin_cordic #(
			.STEPS(CORDIC_STEPS)
		) u_cordic (
			.clk    (clk),
			.arst_n (arst_n),
			.in_vld (start && !busy),
			.angle  (ang[j]),
			.out_vld(cvld[j]),
			.sin_q  (sn[j]),
			.cos_q  (cs[j])
		);
	end

	// ---------------- product network ----------------
	fkin_pkg::kin_t kin_s0, kin_n1, kin_n2, kin_n3, kin_n4, kin_n5, kin_n6;
	fkin_pkg::kin_t kin_s1, kin_s2, kin_s3, kin_s4, kin_s5, kin_s6;
	logic           vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	always_comb begin
		kin_s0    = '0;
		kin_s0.s1 = sn[0]; kin_s0.c1 = cs[0];
		kin_s0.s2 = sn[1]; kin_s0.c2 = cs[1];
		kin_s0.s3 = sn[2]; kin_s0.c3 = cs[2];
		kin_s0.s4 = sn[3]; kin_s0.c4 = cs[3];
		kin_s0.s5 = sn[4]; kin_s0.c5 = cs[4];
		kin_s0.s6 = sn[5]; kin_s0.c6 = cs[5];
		kin_s0.s7 = sn[6]; kin_s0.c7 = cs[6];
	end

	always_comb begin
		kin_n1      = kin_s0;
		kin_n1.c4s6 = fkin_pkg::mq(kin_s0.s6, kin_s0.c4);
		kin_n1.c4c5 = fkin_pkg::mq(kin_s0.c4, kin_s0.c5);
		kin_n1.s4s6 = fkin_pkg::mq(kin_s0.s4, kin_s0.s6);
		kin_n1.s5s7 = fkin_pkg::mq(kin_s0.s5, kin_s0.s7);
		kin_n1.s4c6 = fkin_pkg::mq(kin_s0.s4, kin_s0.c6);
		kin_n1.s5c6 = fkin_pkg::mq(kin_s0.s5, kin_s0.c6);
		kin_n1.s5c4 = fkin_pkg::mq(kin_s0.s5, kin_s0.c4);
		kin_n1.s4c5 = fkin_pkg::mq(kin_s0.s4, kin_s0.c5);
		kin_n1.s4s5 = fkin_pkg::mq(kin_s0.s4, kin_s0.s5);
		kin_n1.c5s7 = fkin_pkg::mq(kin_s0.s7, kin_s0.c5);
		kin_n1.s5s6 = fkin_pkg::mq(kin_s0.s5, kin_s0.s6);
		kin_n1.s3s5 = fkin_pkg::mq(kin_s0.s3, kin_s0.s5);
		kin_n1.s2c3 = fkin_pkg::mq(kin_s0.s2, kin_s0.c3);
		kin_n1.c5c7 = fkin_pkg::mq(kin_s0.c5, kin_s0.c7);
		kin_n1.c2s3 = fkin_pkg::mq(kin_s0.s3, kin_s0.c2);
		kin_n1.c4c6 = fkin_pkg::mq(kin_s0.c4, kin_s0.c6);
		kin_n1.bs4  = fkin_pkg::mq(lb, kin_s0.s4);
		kin_n1.bc4  = fkin_pkg::mq(lb, kin_s0.c4);
		kin_n1.as2  = fkin_pkg::mq(la, kin_s0.s2);
		kin_n1.cs2  = fkin_pkg::mq(lc, kin_s0.s2);
		kin_n1.cc2  = fkin_pkg::mq(lc, kin_s0.c2);
	end

	always_comb begin
		kin_n2        = kin_s1;
		kin_n2.c4c5c6 = fkin_pkg::mq(kin_s1.c4c5, kin_s1.c6);
		kin_n2.c4c5s6 = fkin_pkg::mq(kin_s1.c4s6, kin_s1.c5);
		kin_n2.s5c6s7 = fkin_pkg::mq(kin_s1.s5s7, kin_s1.c6);
		kin_n2.c4s5s7 = fkin_pkg::mq(kin_s1.s5s7, kin_s1.c4);
		kin_n2.s5c6c7 = fkin_pkg::mq(kin_s1.s5c6, kin_s1.c7);
		kin_n2.c4s5c7 = fkin_pkg::mq(kin_s1.s5c4, kin_s1.c7);
		kin_n2.s4c5c6 = fkin_pkg::mq(kin_s1.s4c5, kin_s1.c6);
		kin_n2.s4s5c7 = fkin_pkg::mq(kin_s1.s4s5, kin_s1.c7);
		kin_n2.c3s5s6 = fkin_pkg::mq(kin_s1.s5s6, kin_s1.c3);
		kin_n2.s3s5s6 = fkin_pkg::mq(kin_s1.s3s5, kin_s1.s6);
		kin_n2.s4c5s6 = fkin_pkg::mq(kin_s1.s4s6, kin_s1.c5);
		kin_n2.as4c6  = fkin_pkg::mq(la, kin_s1.s4c6);
		kin_n2.s4s5s7 = fkin_pkg::mq(kin_s1.s4s5, kin_s1.s7);
		kin_n2.ac4c6  = fkin_pkg::mq(la, kin_s1.c4c6);
	end

	always_comb begin
		fkin_pkg::val_t sa, sb, p1, q1, r0, r2;
		sa = kin_s2.s4s6 + kin_s2.c4c5c6;
		sb = kin_s2.s4c5c6 - kin_s2.c4s6;
		p1 = kin_s2.s5c6c7 + kin_s2.c5s7;
		q1 = kin_s2.c5c7 - kin_s2.s5c6s7;
		r0 = kin_s2.c4c5s6 - kin_s2.s4c6;
		r2 = kin_s2.s4c5s6 + kin_s2.c4c6;
		kin_n3           = kin_s2;
		kin_n3.e1        = fkin_pkg::mq(sa, kin_s2.c7);
		kin_n3.e2        = fkin_pkg::mq(sa, kin_s2.s7);
		kin_n3.e3        = fkin_pkg::mq(sb, kin_s2.s7);
		kin_n3.e4        = fkin_pkg::mq(sb, kin_s2.c7);
		kin_n3.ac4c5s6   = fkin_pkg::mq(la, kin_s2.c4c5s6);
		kin_n3.as4c5s6   = fkin_pkg::mq(la, kin_s2.s4c5s6);
		kin_n3.as3s5s6   = fkin_pkg::mq(la, kin_s2.s3s5s6);
		kin_n3.ac3s5s6   = fkin_pkg::mq(la, kin_s2.c3s5s6);
		kin_n3.s3s5s6c2  = fkin_pkg::mq(kin_s2.s3s5s6, kin_s2.c2);
		kin_n3.s2s3s5s6  = fkin_pkg::mq(kin_s2.s2, kin_s2.s3s5s6);
		kin_n3.as2s3s5s6 = fkin_pkg::mq(kin_s2.as2, kin_s2.s3s5s6);
		kin_n3.p1        = p1;
		kin_n3.q1        = q1;
		kin_n3.r0        = r0;
		kin_n3.r2        = r2;
		kin_n3.p1c3      = fkin_pkg::mq(p1, kin_s2.c3);
		kin_n3.p1c2s3    = fkin_pkg::mq(p1, kin_s2.c2s3);
		kin_n3.p1s2      = fkin_pkg::mq(p1, kin_s2.s2);
		kin_n3.q1c3      = fkin_pkg::mq(q1, kin_s2.c3);
		kin_n3.q1c2s3    = fkin_pkg::mq(q1, kin_s2.c2s3);
		kin_n3.q1s2      = fkin_pkg::mq(q1, kin_s2.s2);
		kin_n3.r0s3      = fkin_pkg::mq(r0, kin_s2.s3);
		kin_n3.r0c2      = fkin_pkg::mq(r0, kin_s2.c2);
		kin_n3.r2s2      = fkin_pkg::mq(r2, kin_s2.s2);
		kin_n3.r0s2c3    = fkin_pkg::mq(r0, kin_s2.s2c3);
		kin_n3.r2c2      = fkin_pkg::mq(r2, kin_s2.c2);
	end

	always_comb begin
		fkin_pkg::val_t e6, e8, p0, p2, q0, q2;
		e6 = kin_s3.ac4c5s6 - kin_s3.as4c6 - kin_s3.bs4;
		e8 = kin_s3.as4c5s6 + kin_s3.ac4c6 + kin_s3.bc4 + lc;
		p0 = kin_s3.e1 - kin_s3.c4s5s7;
		p2 = kin_s3.e4 - kin_s3.s4s5s7;
		q0 = -kin_s3.e2 - kin_s3.c4s5c7;
		q2 = -kin_s3.e3 - kin_s3.s4s5c7;
		kin_n4            = kin_s3;
		kin_n4.e6         = e6;
		kin_n4.e8         = e8;
		kin_n4.p0         = p0;
		kin_n4.p2         = p2;
		kin_n4.q0         = q0;
		kin_n4.q2         = q2;
		kin_n4.p0s3       = fkin_pkg::mq(p0, kin_s3.s3);
		kin_n4.p0c2       = fkin_pkg::mq(p0, kin_s3.c2);
		kin_n4.p2s2       = fkin_pkg::mq(p2, kin_s3.s2);
		kin_n4.p0s2c3     = fkin_pkg::mq(p0, kin_s3.s2c3);
		kin_n4.p2c2       = fkin_pkg::mq(p2, kin_s3.c2);
		kin_n4.p1s2s3     = fkin_pkg::mq(kin_s3.p1s2, kin_s3.s3);
		kin_n4.q0s3       = fkin_pkg::mq(q0, kin_s3.s3);
		kin_n4.q0c2       = fkin_pkg::mq(q0, kin_s3.c2);
		kin_n4.q2s2       = fkin_pkg::mq(q2, kin_s3.s2);
		kin_n4.q0s2c3     = fkin_pkg::mq(q0, kin_s3.s2c3);
		kin_n4.q2c2       = fkin_pkg::mq(q2, kin_s3.c2);
		kin_n4.q1s2s3     = fkin_pkg::mq(kin_s3.q1s2, kin_s3.s3);
		kin_n4.r0c2c3     = fkin_pkg::mq(kin_s3.r0c2, kin_s3.c3);
		kin_n4.e6c2       = fkin_pkg::mq(e6, kin_s3.c2);
		kin_n4.e8s2       = fkin_pkg::mq(e8, kin_s3.s2);
		kin_n4.e6s3       = fkin_pkg::mq(e6, kin_s3.s3);
		kin_n4.e6s2c3     = fkin_pkg::mq(e6, kin_s3.s2c3);
		kin_n4.e8c2       = fkin_pkg::mq(e8, kin_s3.c2);
		kin_n4.as3s5s6c2  = fkin_pkg::mq(kin_s3.as3s5s6, kin_s3.c2);
	end

	always_comb begin
		fkin_pkg::val_t u0, u1, u2, v2, w;
		u0 = kin_s4.p0s3 + kin_s4.p1c3;
		u1 = kin_s4.q0s3 + kin_s4.q1c3;
		u2 = kin_s4.r0s3 + kin_s4.c3s5s6;
		v2 = kin_s4.r0c2c3 + kin_s4.r2s2 - kin_s4.s3s5s6c2;
		w  = kin_s4.e6s3 + kin_s4.ac3s5s6;
		kin_n5        = kin_s4;
		kin_n5.p0c2c3 = fkin_pkg::mq(kin_s4.p0c2, kin_s4.c3);
		kin_n5.q0c2c3 = fkin_pkg::mq(kin_s4.q0c2, kin_s4.c3);
		kin_n5.e6c2c3 = fkin_pkg::mq(kin_s4.e6c2, kin_s4.c3);
		kin_n5.u0c1   = fkin_pkg::mq(u0, kin_s4.c1);
		kin_n5.u0s1   = fkin_pkg::mq(u0, kin_s4.s1);
		kin_n5.u1c1   = fkin_pkg::mq(u1, kin_s4.c1);
		kin_n5.u1s1   = fkin_pkg::mq(u1, kin_s4.s1);
		kin_n5.u2c1   = fkin_pkg::mq(u2, kin_s4.c1);
		kin_n5.u2s1   = fkin_pkg::mq(u2, kin_s4.s1);
		kin_n5.v2c1   = fkin_pkg::mq(v2, kin_s4.c1);
		kin_n5.v2s1   = fkin_pkg::mq(v2, kin_s4.s1);
		kin_n5.wc1    = fkin_pkg::mq(w, kin_s4.c1);
		kin_n5.ws1    = fkin_pkg::mq(w, kin_s4.s1);
		kin_n5.m6     = kin_s4.p2c2 - kin_s4.p0s2c3 + kin_s4.p1s2s3;
		kin_n5.m7     = kin_s4.q2c2 - kin_s4.q0s2c3 + kin_s4.q1s2s3;
		kin_n5.m8     = kin_s4.r2c2 - kin_s4.r0s2c3 + kin_s4.s2s3s5s6;
		kin_n5.m11    = kin_s4.e8c2 - kin_s4.e6s2c3 + kin_s4.as2s3s5s6
			+ kin_s4.cc2 + ld;
	end

	always_comb begin
		fkin_pkg::val_t v0, v1, e9;
		v0 = kin_s5.p0c2c3 + kin_s5.p2s2 - kin_s5.p1c2s3;
		v1 = kin_s5.q0c2c3 + kin_s5.q2s2 - kin_s5.q1c2s3;
		e9 = kin_s5.e6c2c3 + kin_s5.e8s2 + kin_s5.cs2 - kin_s5.as3s5s6c2;
		kin_n6      = kin_s5;
		kin_n6.v0c1 = fkin_pkg::mq(v0, kin_s5.c1);
		kin_n6.v0s1 = fkin_pkg::mq(v0, kin_s5.s1);
		kin_n6.v1c1 = fkin_pkg::mq(v1, kin_s5.c1);
		kin_n6.v1s1 = fkin_pkg::mq(v1, kin_s5.s1);
		kin_n6.e9c1 = fkin_pkg::mq(e9, kin_s5.c1);
		kin_n6.e9s1 = fkin_pkg::mq(e9, kin_s5.s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= &cvld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			done   <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		kin_s1 <= kin_n1;
		kin_s2 <= kin_n2;
		kin_s3 <= kin_n3;
		kin_s4 <= kin_n4;
		kin_s5 <= kin_n5;
		kin_s6 <= kin_n6;
	end

	// ---------------- output sums, rounding, clamp ----------------
	logic signed [23:0] o00, o01, o02, o10, o11, o12, o20, o21, o22, ox, oy, oz;

	always_comb begin
		o00 = fkin_pkg::emit(kin_s6.v0c1 - kin_s6.u0s1, fkin_pkg::ROT_LIMIT);
		o01 = fkin_pkg::emit(kin_s6.v1c1 - kin_s6.u1s1, fkin_pkg::ROT_LIMIT);
		o02 = fkin_pkg::emit(kin_s6.v2c1 - kin_s6.u2s1, fkin_pkg::ROT_LIMIT);
		o10 = fkin_pkg::emit(kin_s6.u0c1 + kin_s6.v0s1, fkin_pkg::ROT_LIMIT);
		o11 = fkin_pkg::emit(kin_s6.u1c1 + kin_s6.v1s1, fkin_pkg::ROT_LIMIT);
		o12 = fkin_pkg::emit(kin_s6.u2c1 + kin_s6.v2s1, fkin_pkg::ROT_LIMIT);
		o20 = fkin_pkg::emit(kin_s6.m6, fkin_pkg::ROT_LIMIT);
		o21 = fkin_pkg::emit(kin_s6.m7, fkin_pkg::ROT_LIMIT);
		o22 = fkin_pkg::emit(kin_s6.m8, fkin_pkg::ROT_LIMIT);
		ox  = fkin_pkg::emit(kin_s6.e9c1 - kin_s6.ws1, fkin_pkg::POS_LIMIT);
		oy  = fkin_pkg::emit(kin_s6.wc1 + kin_s6.e9s1, fkin_pkg::POS_LIMIT);
		oz  = fkin_pkg::emit(kin_s6.m11, fkin_pkg::POS_LIMIT);
	end

	always_ff @(posedge clk) begin
		rot_00 <= o00[fkin_pkg::ROT_W-1:0];
		rot_01 <= o01[fkin_pkg::ROT_W-1:0];
		rot_02 <= o02[fkin_pkg::ROT_W-1:0];
		rot_10 <= o10[fkin_pkg::ROT_W-1:0];
		rot_11 <= o11[fkin_pkg::ROT_W-1:0];
		rot_12 <= o12[fkin_pkg::ROT_W-1:0];
		rot_20 <= o20[fkin_pkg::ROT_W-1:0];
		rot_21 <= o21[fkin_pkg::ROT_W-1:0];
		rot_22 <= o22[fkin_pkg::ROT_W-1:0];
		pos_x  <= ox[fkin_pkg::POS_W-1:0];
		pos_y  <= oy[fkin_pkg::POS_W-1:0];
		pos_z  <= oz[fkin_pkg::POS_W-1:0];
	end

	// ---------------- assertions ----------------
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rot_00 <= 18'sd65536) && (rot_00 >= -18'sd65536)
			&& (rot_22 <= 18'sd65536) && (rot_22 >= -18'sd65536))
		else $error("rotation entry out of range");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pos_z <= 20'sd327680) && (pos_z >= -20'sd327680))
		else $error("position out of range");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(cvld == 7'd0) || (cvld == 7'h7f))
		else $error("sine/cosine lanes out of step");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s4 |=> ##2 !done)
		else $error("result beat without an item in flight");

endmodule

FILE: design/fkin_cordic.sv
// ----------------------------------------------------------------------------
// fkin_cordic
// Pipelined CORDIC sine/cosine of one joint angle, one iteration per stage,
// with quadrant folding in front and Q24 rounding behind.
// ----------------------------------------------------------------------------
module fkin_cordic #(
	parameter int STEPS = 18
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_vld,
	input  logic signed [fkin_pkg::ANGLE_W-1:0]   angle,
	output logic                                  out_vld,
	output fkin_pkg::val_t                        sin_q,
	output fkin_pkg::val_t                        cos_q
);

	logic signed [fkin_pkg::XY_W-1:0] x_s [0:STEPS];
	logic signed [fkin_pkg::XY_W-1:0] y_s [0:STEPS];
	logic signed [fkin_pkg::Z_W-1:0]  z_s [0:STEPS];
	logic                             neg_s [0:STEPS];
	logic                             vld_s [0:STEPS];

	logic signed [fkin_pkg::Z_W-1:0]  z_in;
	logic signed [fkin_pkg::XY_W-1:0] xr;
	logic signed [fkin_pkg::XY_W-1:0] yr;
	logic signed [fkin_pkg::XY_W-1:0] xo;
	logic signed [fkin_pkg::XY_W-1:0] yo;

	assign z_in = {angle[fkin_pkg::ANGLE_W-1], angle, 13'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= fkin_pkg::CORDIC_GAIN_Q30;
		y_s[0] <= '0;
		if (z_in > fkin_pkg::HALF_PI_Q28) begin
			z_s[0]   <= z_in - fkin_pkg::PI_Q28;
			neg_s[0] <= 1'b1;
		end else if (z_in < -fkin_pkg::HALF_PI_Q28) begin
			z_s[0]   <= z_in + fkin_pkg::PI_Q28;
			neg_s[0] <= 1'b1;
		end else begin
			z_s[0]   <= z_in;
			neg_s[0] <= 1'b0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			neg_s[i+1] <= neg_s[i];
			if (!z_s[i][fkin_pkg::Z_W-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - fkin_pkg::atan_q28(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + fkin_pkg::atan_q28(i);
			end
		end
	end

	always_comb begin
		xr = neg_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
		yr = neg_s[STEPS] ? -y_s[STEPS] : y_s[STEPS];
		xo = (xr + 34'sd32) >>> 6;
		yo = (yr + 34'sd32) >>> 6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		cos_q <= xo[fkin_pkg::VAL_W-1:0];
		sin_q <= yo[fkin_pkg::VAL_W-1:0];
	end

	// z is never used after the last iteration
	logic unused_z;
	assign unused_z = ^z_s[STEPS];

endmodule
